// ===== hw/rtl/lhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhc_pkg - shared types and constants for the LRU handle cache
// Sizes, the cell entry layout, the per-cell control group and FSM states.
// ----------------------------------------------------------------------------
package lhc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int KEY_BITS    = 64;
	localparam int KEY_IN_BITS = 64;
	localparam int HANDLE_BITS = 64;
	localparam int CAP_BITS    = 7;
	localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_BITS    = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(5);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	typedef struct packed {
		logic                   valid;
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic cmp;   // register key compare result
		logic load;  // take entry from the upstream neighbour
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/lhc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhc_if - channel interfaces of the LRU handle cache
// Request, response and capacity write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lhc_req_if;
	import lhc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic [KEY_IN_BITS-1:0] key;
	logic [HANDLE_BITS-1:0] handle;

	modport source (output valid, output cmd, output key, output handle, input ready);
	modport sink   (input valid, input cmd, input key, input handle, output ready);
endinterface

interface lhc_rsp_if;
	import lhc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [HANDLE_BITS-1:0] found_handle;
	logic                   evicted;
	logic [HANDLE_BITS-1:0] evicted_handle;

	modport source (output valid, output hit, output found_handle, output evicted,
		output evicted_handle, input ready);
	modport sink   (input valid, input hit, input found_handle, input evicted,
		input evicted_handle, output ready);
endinterface

interface lhc_cfg_if;
	import lhc_pkg::*;
	logic                valid;
	logic                ready;
	logic [CAP_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lhc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhc_cell - one position of the recency chain
// Holds one entry, compares it against the request key, and loads the
// entry of its warmer neighbour when told to shift.
// ----------------------------------------------------------------------------
module lhc_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lhc_pkg::cell_ctrl_t             ctrl,
	input  logic [lhc_pkg::KEY_BITS-1:0]    cmp_key,
	input  lhc_pkg::entry_t                 up,
	output lhc_pkg::entry_t                 cur,
	output logic                            match
);
	import lhc_pkg::*;

	logic                   valid_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				valid_q <= up.valid;
			end
			if (ctrl.cmp) begin
				match_q <= valid_q && (key_q == cmp_key);
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q    <= up.key;
			handle_q <= up.handle;
		end
	end

	assign cur.valid  = valid_q;
	assign cur.key    = key_q;
	assign cur.handle = handle_q;
	assign match      = match_q;

endmodule

// ===== hw/rtl/lru_handle_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_handle_cache - fully associative key to handle cache, LRU replacement
// Entries sit in a chain of cells ordered by recency: cell 0 is the warmest.
// Inserts and lookup hits shift a prefix of the chain one cell colder.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents                                | handshake
//  --------+-----+----------------------------------------------+-----------
//  req     | in  | cmd, key, handle                             | valid/ready
//  rsp     | out | hit, found_handle, evicted, evicted_handle   | valid/ready
//  cfg     | in  | data = capacity                              | valid/ready
//
//  Flow: the accept edge in ST_IDLE registers the key compare in every
//  cell; ST_BUSY then shifts the chain and loads the response register.
//  Stalls: while a response waits in the register a new request is still
//  taken and compared; its update holds until the response register frees.
//  Reset: valid bits and count clear at once; no clearing pass. cfg is
//  always ready and takes effect on the next request.
//
module lru_handle_cache (
	input  logic        clk,
	input  logic        arst_n,
	lhc_req_if.sink     req,
	lhc_rsp_if.source   rsp,
	lhc_cfg_if.sink     cfg
);
	import lhc_pkg::*;

	localparam logic [MAX_ENTRIES-1:0] ONE_V = {{(MAX_ENTRIES-1){1'b0}}, 1'b1};
	localparam logic [CMP_BITS-1:0]    MAX_C = CMP_BITS'(MAX_ENTRIES);

	// ---- control state
	state_t              state_q, state_d;
	logic [CAP_BITS-1:0] capacity_q;
	logic [CNT_BITS-1:0] entry_count_q;

	// ---- captured request
	logic                   cmd_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// ---- response register
	logic                   rsp_valid_q;
	logic                   hit_q;
	logic [HANDLE_BITS-1:0] found_q;
	logic                   evicted_q;
	logic [HANDLE_BITS-1:0] evh_q;

	// ---- chain
	cell_ctrl_t             ctrl   [MAX_ENTRIES];
	entry_t                 cur    [MAX_ENTRIES];
	entry_t                 up     [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match_v;
	logic [MAX_ENTRIES-1:0] valid_v;

	logic                   req_acc;
	logic                   rsp_free;
	logic                   upd;
	logic                   cmp_en;

	logic [MAX_ENTRIES-1:0] first_v;  // warmest matching cell, one-hot
	logic [MAX_ENTRIES-1:0] last_v;   // coldest valid cell, one-hot
	logic [MAX_ENTRIES-1:0] hit_mask; // cells 0..match position
	logic [MAX_ENTRIES-1:0] load_v;
	logic                   any_hit;
	logic                   evict;
	logic [CMP_BITS-1:0]    cap_eff;
	logic [CMP_BITS-1:0]    cnt_w;
	entry_t                 sel_e;    // entry of the warmest match
	logic [HANDLE_BITS-1:0] last_h;   // handle of the coldest entry
	entry_t                 head;

	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign req_acc  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// ---- FSM: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- FSM: outputs
	always_comb begin
		req.ready = 1'b0;
		upd       = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_BUSY: upd       = rsp_free;
			default: begin
				req.ready = 1'b0;
				upd       = 1'b0;
			end
		endcase
	end

	assign cmp_en = req_acc;

	// ---- eviction decision; capacity saturates at the chain length
	assign cnt_w   = CMP_BITS'(entry_count_q);
	assign cap_eff = (CMP_BITS'(capacity_q) > MAX_C) ? MAX_C : CMP_BITS'(capacity_q);
	assign evict   = (cmd_q == CMD_INSERT) && (cnt_w >= cap_eff) && (entry_count_q != '0);

	// ---- match resolution: isolate lowest set bit, then mask up to it
	assign first_v  = match_v & (~match_v + ONE_V);
	assign any_hit  = |match_v;
	assign hit_mask = first_v | (first_v - ONE_V);
	assign last_v   = valid_v & ~(valid_v >> 1);

	always_comb begin
		sel_e  = '0;
		last_h = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			sel_e  = sel_e  | (first_v[i] ? cur[i] : '0);
			last_h = last_h | (last_v[i]  ? cur[i].handle : '0);
		end
	end

	// new entry for cell 0: the request on insert, the promoted entry on a hit
	always_comb begin
		if (cmd_q == CMD_INSERT) begin
			head.valid  = 1'b1;
			head.key    = key_q;
			head.handle = handle_q;
		end else begin
			head = sel_e;
		end
	end

	always_comb begin
		if (cmd_q == CMD_INSERT) begin
			// on eviction the coldest cell is overwritten by its neighbour
			load_v = evict ? valid_v : '1;
		end else begin
			load_v = any_hit ? hit_mask : '0;
		end
	end

	// ---- chain of cells
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign up[g] = head;
		end else begin : g_link
			assign up[g] = cur[g-1];
		end
		assign ctrl[g].cmp  = cmp_en;
		assign ctrl[g].load = upd && load_v[g];
		assign valid_v[g]   = cur[g].valid;

		lhc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl[g]),
			.cmp_key (req.key[KEY_BITS-1:0]),
			.up      (up[g]),
			.cur     (cur[g]),
			.match   (match_v[g])
		);
	end

	// ---- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			capacity_q    <= CAP_RESET;
			entry_count_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				capacity_q <= cfg.data;
			end
			if (upd && (cmd_q == CMD_INSERT) && !evict) begin
				entry_count_q <= entry_count_q + CNT_BITS'(1);
			end
			if (upd) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ---- request capture and response payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q    <= req.cmd;
			key_q    <= req.key[KEY_BITS-1:0];
			handle_q <= req.handle;
		end
		if (upd) begin
			if (cmd_q == CMD_INSERT) begin
				hit_q     <= 1'b0;
				found_q   <= '0;
				evicted_q <= evict;
				evh_q     <= evict ? last_h : '0;
			end else begin
				hit_q     <= any_hit;
				found_q   <= any_hit ? sel_e.handle : '0;
				evicted_q <= 1'b0;
				evh_q     <= '0;
			end
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = hit_q;
	assign rsp.found_handle   = found_q;
	assign rsp.evicted        = evicted_q;
	assign rsp.evicted_handle = evh_q;

	// ---- assertions
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_v) == int'(entry_count_q))
		else $error("entry count differs from valid cells");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_v & (valid_v + ONE_V)) == '0)
		else $error("valid cells not a contiguous warm prefix");

	a_single_first: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_v))
		else $error("more than one warmest match");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(hit_q && evicted_q))
		else $error("response shows hit and eviction together");

endmodule

// ===== test/tb_lru_handle_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_handle_cache - self-checking bench for the LRU handle cache
// Sends insert and lookup beats with random request gaps, under random
// response back-pressure, and walks the capacity through several settings,
// including both extremes. A recency-ordered shadow list predicts each
// response beat, which is then checked field by field.
// ----------------------------------------------------------------------------
module tb_lru_handle_cache;
	import lhc_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int NUM_PHASES     = 10;
	localparam int POOL_DEPTH     = 16;

	// one cached line of the shadow list
	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} line_t;

	// one response beat
	typedef struct packed {
		logic                   hit;
		logic [HANDLE_BITS-1:0] found_handle;
		logic                   evicted;
		logic [HANDLE_BITS-1:0] evicted_handle;
	} response_t;

	// ------------------------------------------------------------------------
	// Shadow of the cache. Lines are kept warmest first, so the coldest line
	// is always the back of the queue and the warmest match is the first hit
	// of a front-to-back search.
	// ------------------------------------------------------------------------
	class handle_cache_shadow;
		line_t               lines[$];
		response_t           pending_results[$];
		logic [CAP_BITS-1:0] capacity;
		int                  errors;

		function new();
			capacity = CAP_RESET;
			errors   = 0;
		endfunction

		function void set_capacity(logic [CAP_BITS-1:0] value);
			capacity = value;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// work out the response to an accepted request beat
		function void take_request(cmd_t op, logic [KEY_IN_BITS-1:0] key_in,
			logic [HANDLE_BITS-1:0] handle_in);
			response_t           res;
			line_t               entry;
			int                  limit;
			int                  idx;
			logic [KEY_BITS-1:0] key;

			res   = '0;
			key   = key_in[KEY_BITS-1:0];
			// capacity saturates at the table depth
			limit = (int'(capacity) > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
			if (op == CMD_INSERT) begin
				// at or above capacity: drop the coldest line first
				// (capacity zero still lets an empty cache take one line)
				if (lines.size() >= limit && lines.size() > 0) begin
					entry              = lines.pop_back();
					res.evicted        = 1'b1;
					res.evicted_handle = entry.handle;
				end
				entry.key    = key;
				entry.handle = handle_in;
				lines.push_front(entry);
			end else begin
				idx = -1;
				foreach (lines[i])
					if (idx < 0 && lines[i].key == key)
						idx = i;
				if (idx >= 0) begin
					entry = lines[idx];
					lines.delete(idx);
					lines.push_front(entry);
					res.hit          = 1'b1;
					res.found_handle = entry.handle;
				end
			end
			pending_results.push_back(res);
		endfunction

		// compare an accepted response beat with the oldest prediction
		function void match_response(response_t got);
			response_t want;

			if (pending_results.size() == 0) begin
				$error("response beat with no request outstanding");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				errors++;
			end
			if (got.found_handle !== want.found_handle) begin
				$error("found_handle: expected %h, got %h", want.found_handle,
					got.found_handle);
				errors++;
			end
			if (got.evicted !== want.evicted) begin
				$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
				errors++;
			end
			if (got.evicted_handle !== want.evicted_handle) begin
				$error("evicted_handle: expected %h, got %h", want.evicted_handle,
					got.evicted_handle);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lhc_req_if req();
	lhc_rsp_if rsp();
	lhc_cfg_if cfg();

	lru_handle_cache uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	handle_cache_shadow shadow = new();

	// set for the closing phase: no idling on either side
	bit calm_tail = 1'b0;
	int stall_left = 0;
	int stalled_cycles = 0;

	// Capacity schedule. Zero and 127 are the extremes (127 saturates at the
	// table depth); the 127 phase fills the table so that the drop to 3
	// afterwards runs with the count well above the capacity.
	int phase_capacity[NUM_PHASES] = '{0, 1, 127, 64, 3, 20, 2, 7, 40, 5};
	int phase_items[NUM_PHASES]    = '{60, 60, 150, 100, 80, 100, 60, 100, 100, 40};

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Beat monitor. Runs at the rising edge, so it sees the values that the
	// edge itself samples. The response is checked before the request is
	// noted: a request taken at this edge cannot own the response that
	// leaves at the same edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : beat_monitor
		response_t got;

		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got.hit            = rsp.hit;
				got.found_handle   = rsp.found_handle;
				got.evicted        = rsp.evicted;
				got.evicted_handle = rsp.evicted_handle;
				shadow.match_response(got);
			end
			if (req.valid && req.ready)
				shadow.take_request(cmd_t'(req.cmd), req.key, req.handle);
		end
	end

	// Watchdog: too long without a beat on any channel means a hang.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Response back-pressure: random stall bursts, long runs open.
	always @(negedge clk) begin
		if (calm_tail) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Entered and left at a falling edge. Valid is only lowered for an idle
	// burst, so back-to-back beats keep it high without a glitch.
	task automatic send_request(input cmd_t op, input logic [KEY_IN_BITS-1:0] key,
		input logic [HANDLE_BITS-1:0] handle);
		if (!calm_tail && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req.valid  <= 1'b1;
		req.cmd    <= op;
		req.key    <= key;
		req.handle <= handle;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// Hold off requests until every predicted response has left, plus some margin.
	task automatic wait_until_drained();
		req.valid <= 1'b0;
		while (shadow.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// only called with the cache drained
	task automatic write_capacity(input logic [CAP_BITS-1:0] value);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		shadow.set_capacity(value);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Mostly inserts and lookups over a small key pool so that hits,
	// duplicates and evictions are common; a tenth is fully random noise.
	task automatic run_traffic(input int count, input int cap);
		logic [63:0] pool[POOL_DEPTH];
		int          pool_size;
		int          pick;

		pool_size = (cap < 8) ? cap + 2 : POOL_DEPTH;
		foreach (pool[i])
			pool[i] = rand64();
		if ($urandom_range(0, 1))
			pool[0] = '0;
		if ($urandom_range(0, 1))
			pool[1] = '1;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_request(CMD_INSERT, pool[$urandom_range(0, pool_size - 1)], rand64());
			else if (pick < 90)
				send_request(CMD_LOOKUP, pool[$urandom_range(0, pool_size - 1)], rand64());
			else
				send_request(cmd_t'($urandom_range(0, 1)), rand64(), rand64());
		end
	endtask

	initial begin
		req.valid  = 1'b0;
		req.cmd    = CMD_INSERT;
		req.key    = '0;
		req.handle = '0;
		rsp.ready  = 1'b0;
		cfg.valid  = 1'b0;
		cfg.data   = '0;
		arst_n     = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part, at the reset capacity of 5 ---
		// lookup in an empty cache
		send_request(CMD_LOOKUP, '0, '1);
		// extreme keys and handles
		send_request(CMD_INSERT, '0, '1);
		send_request(CMD_INSERT, '1, '0);
		send_request(CMD_LOOKUP, '0, '0);
		send_request(CMD_LOOKUP, '1, '0);
		// duplicate key: the newer, warmer copy must win
		send_request(CMD_INSERT, '0, 64'h0123_4567_89AB_CDEF);
		send_request(CMD_LOOKUP, '0, '0);
		// fill to capacity, then evict
		send_request(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(CMD_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_INSERT, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
		send_request(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		send_request(CMD_INSERT, 64'h1, 64'h1);
		send_request(CMD_INSERT, 64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF);
		// evicted keys must now miss; the older duplicate of key 0 is gone
		send_request(CMD_LOOKUP, '1, '0);
		send_request(CMD_LOOKUP, '0, '0);
		send_request(CMD_LOOKUP, 64'hDEAD_BEEF_DEAD_BEEF, '0);

		// --- random part, one capacity setting per phase ---
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_until_drained();
			if (p == NUM_PHASES - 1)
				calm_tail = 1'b1;
			write_capacity(phase_capacity[p][CAP_BITS-1:0]);
			if (p == 3) begin
				// sender holds off mid-phase until the cache has drained
				run_traffic(phase_items[p] / 2, phase_capacity[p]);
				wait_until_drained();
				run_traffic(phase_items[p] - phase_items[p] / 2, phase_capacity[p]);
			end else begin
				run_traffic(phase_items[p], phase_capacity[p]);
			end
		end

		wait_until_drained();
		repeat (10) @(negedge clk);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lhc_pkg.sv
hw/rtl/lhc_if.sv
hw/rtl/lhc_cell.sv
hw/rtl/lru_handle_cache.sv
test/tb_lru_handle_cache.sv
